// ----- rtl/lse_pkg.sv -----
package lse_pkg;

    localparam int VAL_W   = 24;
    localparam int TAB_LEN = 29;
    localparam int TAB_IW  = 5;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 24'sh800000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 24'sh7FFFFF;

    // exp(-2^-24) in Q0.62, seed of the squaring chain
    localparam logic [61:0] TAB0    = 62'h3FFF_FFC0_0000_2000;
    localparam logic [62:0] Q62_ONE = 63'h4000_0000_0000_0000;
    localparam logic [63:0] LN2_Q64 = 64'hB172_17F7_D1CF_79AC;

    // multiplier operand select
    localparam logic [1:0] MS_TAB = 2'd0;
    localparam logic [1:0] MS_EXP = 2'd1;
    localparam logic [1:0] MS_SQ  = 2'd2;
    localparam logic [1:0] MS_LN  = 2'd3;

    typedef struct packed {
        logic signed [VAL_W-1:0] log_value;
        logic                    value_is_zero;
        logic                    last_term;
    } t_term_beat;

    typedef struct packed {
        logic signed [VAL_W-1:0] sum_value;
        logic                    sum_is_zero;
    } t_result_beat;

    typedef struct packed {
        logic              in_ready;
        logic              mul_start;
        logic [1:0]        mul_sel;
        logic [TAB_IW-1:0] tab_idx;
        logic [TAB_IW-1:0] bit_idx;
        logic              tab_wr;
        logic              rd_en;
        logic              term_load;
        logic              acc_upd;
        logic              sum_clr;
        logic              sum_add;
        logic              norm_load;
        logic              norm_shift;
        logic              sq_upd;
        logic              res_load;
        logic              res_zero;
    } t_cmd;

    typedef struct packed {
        logic in_fire;
        logic in_last;
        logic nz_zero;
        logic idx_last;
        logic d_big;
        logic d_bit;
        logic mul_done;
        logic m_norm;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/lse_stream_if.sv -----
interface lse_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/lse_ram.sv -----
module lse_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// ----- rtl/lse_mul.sv -----
// 64x64 unsigned multiply, one 32x32 partial product per cycle
module lse_mul (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic         o_done,
    output logic [127:0] o_prod
);
    logic [63:0]  r_a, r_b, r_pp;
    logic [127:0] r_acc;
    logic [2:0]   r_step;
    logic         r_busy, r_done;
    logic [31:0]  w_x, w_y;
    logic [63:0]  w_pp;
    logic [127:0] w_add;

    assign w_x  = r_step[1] ? r_a[63:32] : r_a[31:0];
    assign w_y  = r_step[0] ? r_b[63:32] : r_b[31:0];
    assign w_pp = w_x * w_y;

    always_comb begin
        case (r_step)
            3'd1:          w_add = {64'd0, r_pp};
            3'd2, 3'd3:    w_add = {32'd0, r_pp, 32'd0};
            3'd4:          w_add = {r_pp, 64'd0};
            default:       w_add = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_step == 3'd4);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                if (r_step == 3'd4) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_pp  <= w_pp;
            r_acc <= r_acc + w_add;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

// ----- rtl/lse_dp.sv -----
module lse_dp #(
    parameter int MAX_TERMS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lse_pkg::t_cmd                i_cmd,
    input  logic [$clog2(MAX_TERMS)-1:0] i_rd_addr,
    output lse_pkg::t_sts                o_sts,
    input  logic                         i_in_valid,
    input  lse_pkg::t_term_beat          i_in_data,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output lse_pkg::t_result_beat        o_out_data
);
    import lse_pkg::*;

    localparam int ADDR_W = $clog2(MAX_TERMS);
    localparam int CNT_W  = $clog2(MAX_TERMS + 1);
    localparam int SUM_W  = 33 + $clog2(MAX_TERMS);
    localparam int E_W    = $clog2(SUM_W - 32);
    localparam logic [29:0]       D_LIM   = 30'(32) << FRAC_BITS;
    localparam logic [TAB_IW-1:0] TAB_OFS = TAB_IW'(24 - FRAC_BITS);
    localparam logic [63:0]       RND     = 64'd1 << (31 - FRAC_BITS);
    localparam logic signed [39:0] RES_HI = 40'(VAL_MAX);

    logic [CNT_W-1:0]        r_nz;
    logic signed [VAL_W-1:0] r_max;
    logic [61:0]             r_tab [TAB_LEN];
    logic [VAL_W-1:0]        r_d;
    logic [62:0]             r_acc;
    logic [SUM_W-1:0]        r_sum;
    logic [63:0]             r_m;
    logic [E_W-1:0]          r_e;
    logic [31:0]             r_frac;
    logic                    r_out_valid;
    t_result_beat            r_out;

    logic                    w_fire, w_store;
    logic [VAL_W-1:0]        w_rdata;
    logic signed [VAL_W:0]   w_diff;
    logic [TAB_IW-1:0]       w_tidx, w_widx;
    logic [61:0]             w_tval;
    logic [63:0]             w_ma, w_mb;
    logic                    w_mdone;
    logic [127:0]            w_prod;
    logic [29:0]             w_dx;
    logic [63:0]             w_ln_r;
    logic signed [39:0]      w_res;
    logic [CNT_W-1:0]        w_rd_cnt;

    assign w_fire  = i_in_valid && i_cmd.in_ready;
    assign w_store = w_fire && !i_in_data.value_is_zero && (r_nz < CNT_W'(MAX_TERMS));

    lse_ram #(.WIDTH(VAL_W), .DEPTH(MAX_TERMS)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (r_nz[ADDR_W-1:0]),
        .i_wdata (i_in_data.log_value),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (w_rdata)
    );

    assign w_tidx = (i_cmd.mul_sel == MS_EXP) ? i_cmd.bit_idx + TAB_OFS : i_cmd.tab_idx;
    assign w_widx = i_cmd.tab_idx + TAB_IW'(1);
    assign w_tval = (w_tidx == '0) ? TAB0 : r_tab[w_tidx];

    always_comb begin
        case (i_cmd.mul_sel)
            MS_TAB: begin
                w_ma = {2'b00, w_tval};
                w_mb = {2'b00, w_tval};
            end
            MS_EXP: begin
                w_ma = {1'b0, r_acc};
                w_mb = {2'b00, w_tval};
            end
            MS_SQ: begin
                w_ma = r_m;
                w_mb = r_m;
            end
            default: begin
                w_ma = {(32 - E_W)'(0), r_e, r_frac};
                w_mb = LN2_Q64;
            end
        endcase
    end

    lse_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mdone),
        .o_prod  (w_prod)
    );

    assign w_diff = {r_max[VAL_W-1], r_max} - {w_rdata[VAL_W-1], w_rdata};
    assign w_dx   = {6'd0, r_d};
    assign w_rd_cnt = CNT_W'(i_rd_addr);

    // round ln to FRAC_BITS, add the maximum
    assign w_ln_r = (w_prod[127:64] + RND) >> (32 - FRAC_BITS);
    assign w_res  = 40'(r_max) + $signed({1'b0, w_ln_r[38:0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nz        <= '0;
            r_max       <= VAL_MIN;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
                r_nz        <= '0;
                r_max       <= VAL_MIN;
            end else if (w_store) begin
                r_nz <= r_nz + CNT_W'(1);
                if (r_nz == '0 || i_in_data.log_value > r_max) begin
                    r_max <= i_in_data.log_value;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tab_wr) begin
            r_tab[w_widx] <= w_prod[123:62];
        end
        if (i_cmd.term_load) begin
            r_d   <= w_diff[VAL_W-1:0];
            r_acc <= Q62_ONE;
        end else if (i_cmd.acc_upd) begin
            r_acc <= w_prod[124:62];
        end
        if (i_cmd.sum_clr) begin
            r_sum <= '0;
        end else if (i_cmd.sum_add) begin
            r_sum <= r_sum + SUM_W'(r_acc[62:30]);
        end
        if (i_cmd.norm_load) begin
            r_m    <= {1'b0, r_sum, {(63 - SUM_W){1'b0}}};
            r_e    <= E_W'(SUM_W - 33);
            r_frac <= '0;
        end else if (i_cmd.norm_shift) begin
            r_m <= {r_m[62:0], 1'b0};
            r_e <= r_e - E_W'(1);
        end else if (i_cmd.sq_upd) begin
            // square of m in [1,2) lands in [1,4): a carry is the next log2 bit
            r_m    <= w_prod[125] ? {1'b0, w_prod[125:63]} : w_prod[125:62];
            r_frac <= {r_frac[30:0], w_prod[125]};
        end
        if (i_cmd.res_load) begin
            r_out.sum_is_zero <= i_cmd.res_zero;
            if (i_cmd.res_zero) begin
                r_out.sum_value <= VAL_MIN;
            end else if (w_res > RES_HI) begin
                r_out.sum_value <= VAL_MAX;
            end else begin
                r_out.sum_value <= w_res[VAL_W-1:0];
            end
        end
    end

    assign o_sts.in_fire  = w_fire;
    assign o_sts.in_last  = i_in_data.last_term;
    assign o_sts.nz_zero  = (r_nz == '0);
    assign o_sts.idx_last = (w_rd_cnt + CNT_W'(1)) == r_nz;
    assign o_sts.d_big    = w_dx >= D_LIM;
    assign o_sts.d_bit    = w_dx[i_cmd.bit_idx];
    assign o_sts.mul_done = w_mdone;
    assign o_sts.m_norm   = r_m[62];
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_nz_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nz <= CNT_W'(MAX_TERMS))
        else $error("stored term count past capacity");
    a_res_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwrites an untaken beat");
    a_res_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_load |=> r_out_valid && r_nz == '0)
        else $error("result load did not present a beat and clear the set");
    a_rd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> (w_rd_cnt < r_nz))
        else $error("read of an entry not in the set");
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.in_ready |-> !i_cmd.mul_start && !i_cmd.res_load)
        else $error("input taken while datapath busy");
`endif
endmodule

// ----- rtl/lse_ctrl.sv -----
module lse_ctrl #(
    parameter int MAX_TERMS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lse_pkg::t_sts                i_sts,
    output lse_pkg::t_cmd                o_cmd,
    output logic [$clog2(MAX_TERMS)-1:0] o_rd_addr
);
    import lse_pkg::*;

    localparam int ADDR_W = $clog2(MAX_TERMS);
    localparam logic [TAB_IW-1:0] BIT_END = TAB_IW'(FRAC_BITS + 5);
    localparam logic [4:0] TAB_LAST = 5'(TAB_LEN - 2);

    localparam logic [3:0] S_TB_START = 4'd0;
    localparam logic [3:0] S_TB_WAIT  = 4'd1;
    localparam logic [3:0] S_LOAD     = 4'd2;
    localparam logic [3:0] S_CHECK    = 4'd3;
    localparam logic [3:0] S_RD       = 4'd4;
    localparam logic [3:0] S_TERM     = 4'd5;
    localparam logic [3:0] S_SCAN     = 4'd6;
    localparam logic [3:0] S_EWAIT    = 4'd7;
    localparam logic [3:0] S_NEXT     = 4'd8;
    localparam logic [3:0] S_NORM     = 4'd9;
    localparam logic [3:0] S_SQ_START = 4'd10;
    localparam logic [3:0] S_SQ_WAIT  = 4'd11;
    localparam logic [3:0] S_LN_START = 4'd12;
    localparam logic [3:0] S_LN_WAIT  = 4'd13;
    localparam logic [3:0] S_DONE     = 4'd14;

    logic [3:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [TAB_IW-1:0] r_bit, n_bit;
    logic [4:0]        r_cnt, n_cnt;
    logic              r_zero, n_zero;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_bit   = r_bit;
        n_cnt   = r_cnt;
        n_zero  = r_zero;
        o_cmd   = '0;
        o_cmd.tab_idx = r_cnt;
        o_cmd.bit_idx = r_bit;
        case (r_state)
            S_TB_START: begin
                o_cmd.mul_sel   = MS_TAB;
                o_cmd.mul_start = 1'b1;
                n_state         = S_TB_WAIT;
            end
            S_TB_WAIT: begin
                o_cmd.mul_sel = MS_TAB;
                if (i_sts.mul_done) begin
                    o_cmd.tab_wr = 1'b1;
                    if (r_cnt == TAB_LAST) begin
                        n_state = S_LOAD;
                    end else begin
                        n_cnt   = r_cnt + 5'd1;
                        n_state = S_TB_START;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_fire && i_sts.in_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_idx         = '0;
                o_cmd.sum_clr = 1'b1;
                if (i_sts.nz_zero) begin
                    n_zero  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_zero  = 1'b0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_TERM;
            end
            S_TERM: begin
                o_cmd.term_load = 1'b1;
                n_bit           = '0;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.mul_sel = MS_EXP;
                if (i_sts.d_big) begin
                    n_state = S_NEXT;
                end else if (r_bit == BIT_END) begin
                    o_cmd.sum_add = 1'b1;
                    n_state       = S_NEXT;
                end else if (i_sts.d_bit) begin
                    o_cmd.mul_start = 1'b1;
                    n_state         = S_EWAIT;
                end else begin
                    n_bit = r_bit + TAB_IW'(1);
                end
            end
            S_EWAIT: begin
                o_cmd.mul_sel = MS_EXP;
                if (i_sts.mul_done) begin
                    o_cmd.acc_upd = 1'b1;
                    n_bit         = r_bit + TAB_IW'(1);
                    n_state       = S_SCAN;
                end
            end
            S_NEXT: begin
                if (i_sts.idx_last) begin
                    o_cmd.norm_load = 1'b1;
                    n_state         = S_NORM;
                end else begin
                    n_idx   = r_idx + ADDR_W'(1);
                    n_state = S_RD;
                end
            end
            S_NORM: begin
                if (i_sts.m_norm) begin
                    n_cnt   = '0;
                    n_state = S_SQ_START;
                end else begin
                    o_cmd.norm_shift = 1'b1;
                end
            end
            S_SQ_START: begin
                o_cmd.mul_sel   = MS_SQ;
                o_cmd.mul_start = 1'b1;
                n_state         = S_SQ_WAIT;
            end
            S_SQ_WAIT: begin
                o_cmd.mul_sel = MS_SQ;
                if (i_sts.mul_done) begin
                    o_cmd.sq_upd = 1'b1;
                    n_cnt        = r_cnt + 5'd1;
                    n_state      = (r_cnt == 5'd31) ? S_LN_START : S_SQ_START;
                end
            end
            S_LN_START: begin
                o_cmd.mul_sel   = MS_LN;
                o_cmd.mul_start = 1'b1;
                n_state         = S_LN_WAIT;
            end
            S_LN_WAIT: begin
                o_cmd.mul_sel = MS_LN;
                if (i_sts.mul_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.mul_sel  = MS_LN;
                o_cmd.res_zero = r_zero;
                if (i_sts.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_TB_START;
            r_idx   <= '0;
            r_bit   <= '0;
            r_cnt   <= '0;
            r_zero  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_bit   <= n_bit;
            r_cnt   <= n_cnt;
            r_zero  <= n_zero;
        end
    end

    assign o_rd_addr = r_idx;
endmodule

// ----- rtl/log_sum_exp_reducer.sv -----
// channel   dir  beat payload                             moves when
// i_term    in   log_value, value_is_zero, last_term      valid & ready
// o_result  out  sum_value, sum_is_zero                   valid & ready
//
// Terms load one per cycle. After a last term the set is reduced: per stored
// term FRAC_BITS + 5 bits of (max - term) are scanned, each set bit one pass
// through the shared 64x64 multiplier; then up to log2(MAX_TERMS) normalize
// shifts, 32 squarings and one ln2 multiply.
// After reset the exp table is built by 28 squarings, no input taken.
// The result sits in an output register; the next set loads while it waits.
module log_sum_exp_reducer #(
    parameter int MAX_TERMS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lse_stream_if.sink   i_term,
    lse_stream_if.source o_result
);
    import lse_pkg::*;

    t_cmd                         w_cmd;
    t_sts                         w_sts;
    logic [$clog2(MAX_TERMS)-1:0] w_rd_addr;

    lse_ctrl #(.MAX_TERMS(MAX_TERMS), .FRAC_BITS(FRAC_BITS)) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd),
        .o_rd_addr (w_rd_addr)
    );

    lse_dp #(.MAX_TERMS(MAX_TERMS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_rd_addr   (w_rd_addr),
        .o_sts       (w_sts),
        .i_in_valid  (i_term.valid),
        .i_in_data   (i_term.data),
        .i_out_ready (o_result.ready),
        .o_out_valid (o_result.valid),
        .o_out_data  (o_result.data)
    );

    assign i_term.ready = w_cmd.in_ready;
endmodule
